// File: rtl/ocsc_pkg.sv
// ----------------------------------------------------------------------------
// ocsc_pkg: shared types and constants for the column span clipper
// Entry layout of the occluded range list, compare result bundle, action
// codes and sentinel values.
// ----------------------------------------------------------------------------
package ocsc_pkg;

  localparam int MAX_RANGES_DEF = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int COL_W          = 12;
  localparam int VW_W           = 13;
  localparam int ENT_W          = 16;

  localparam logic [VW_W-1:0] VIEW_WIDTH_RESET = 13'd320;

  localparam logic signed [ENT_W-1:0] SENT_LO        = -16'sd32767;
  localparam logic signed [ENT_W-1:0] SENT_HI        = 16'sd32767;
  localparam logic signed [ENT_W-1:0] SENT_LEFT_LAST = -16'sd1;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_SOLID = 2'd1;
  localparam logic [1:0] ACT_PASS  = 2'd2;

  typedef struct packed {
    logic signed [ENT_W-1:0] first;
    logic signed [ENT_W-1:0] last;
  } entry_t;

  typedef struct packed {
    logic             last_lt_fm1;
    logic             f_lt_first;
    logic             l_lt_firstm1;
    logic             l_le_last;
    logic [COL_W-1:0] first_m1;
    logic [COL_W-1:0] last_p1;
  } cmp_t;

endpackage

// File: rtl/ocsc_ram.sv
// ----------------------------------------------------------------------------
// ocsc_ram: occluded range list storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ocsc_ram
  import ocsc_pkg::*;
#(
  parameter int DEPTH = MAX_RANGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ocsc_unit.sv
// ----------------------------------------------------------------------------
// ocsc_unit: shared compare unit
// Compares the current span against one list entry and forms the fragment
// edges next to that entry. Used by the scan, head and walk steps.
// ----------------------------------------------------------------------------
module ocsc_unit
  import ocsc_pkg::*;
(
  input  entry_t           ent,
  input  logic [COL_W-1:0] f_col,
  input  logic [COL_W-1:0] l_col,
  output cmp_t             res
);

  logic signed [ENT_W:0] f_s;
  logic signed [ENT_W:0] l_s;
  logic signed [ENT_W:0] first_s;
  logic signed [ENT_W:0] last_s;
  logic signed [ENT_W:0] f_m1;
  logic signed [ENT_W:0] first_m1;
  logic signed [ENT_W:0] last_p1;

  assign f_s      = {{(ENT_W + 1 - COL_W){1'b0}}, f_col};
  assign l_s      = {{(ENT_W + 1 - COL_W){1'b0}}, l_col};
  assign first_s  = {ent.first[ENT_W-1], ent.first};
  assign last_s   = {ent.last[ENT_W-1], ent.last};
  assign f_m1     = f_s - 17'sd1;
  assign first_m1 = first_s - 17'sd1;
  assign last_p1  = last_s + 17'sd1;

  assign res.last_lt_fm1  = last_s < f_m1;
  assign res.f_lt_first   = f_s < first_s;
  assign res.l_lt_firstm1 = l_s < first_m1;
  assign res.l_le_last    = l_s <= last_s;
  assign res.first_m1     = first_m1[COL_W-1:0];
  assign res.last_p1      = last_p1[COL_W-1:0];

endmodule

// File: rtl/occluded_column_span_clipper.sv
// ----------------------------------------------------------------------------
// occluded_column_span_clipper: solid segment column clip list
// Keeps a sorted list of occluded column ranges and reports the visible
// fragments of each span, merging solid spans into the list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel span_valid/span_stall carries action, first_column and
//   last_column. Output channel result_valid/result_stall carries one item per
//   visible fragment; run_end marks the last item of a span. A span with no
//   visible part gives one item with frag_valid low.
//   view_width is written through cfg_wr_en/cfg_wr_data; it takes effect at the
//   next clear. The user must write only while idle; the block does not enforce.
// Operation:
//   A span is taken only when the sequencer is idle. The walk reads one list
//   entry per cycle, unless the result output stalls, through a single memory
//   read port: it scans to the first touched entry s, then steps through each
//   covered gap; a solid span then writes back the merged entry and compacts
//   the list, or shifts later entries up and inserts itself into its gap.
// Reset:
//   States CLR0 then CLR1 write the sentinels for a width of 320 columns; span
//   stall stays high meanwhile. A stalled receiver holds the sequencer at the
//   next fragment, while the span channel stays stalled.
// ----------------------------------------------------------------------------
module occluded_column_span_clipper
  import ocsc_pkg::*;
#(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [VW_W-1:0]  cfg_wr_data,
  input  logic             span_valid,
  output logic             span_stall,
  input  logic [1:0]       action,
  input  logic [COL_W-1:0] first_column,
  input  logic [COL_W-1:0] last_column,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             frag_valid,
  output logic [COL_W-1:0] frag_first,
  output logic [COL_W-1:0] frag_last,
  output logic             run_end,
  output logic             overflow
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_CLR0    = 11'b00000000010,
    ST_CLR1    = 11'b00000000100,
    ST_SCAN    = 11'b00000001000,
    ST_HEAD    = 11'b00000010000,
    ST_WALK    = 11'b00000100000,
    ST_SHIFT   = 11'b00001000000,
    ST_INS     = 11'b00010000000,
    ST_WB      = 11'b00100000000,
    ST_COMPACT = 11'b01000000000,
    ST_EMPTY   = 11'b10000000000
  } state_t;

  state_t               state;
  logic                 init_pend;
  logic [VW_W-1:0]      view_width_r;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        nx;
  logic [CW-1:0]        ck;
  logic [CW-1:0]        gone;
  entry_t               ent;
  logic [COL_W-1:0]     gap_first;
  logic [COL_W-1:0]     f_col;
  logic [COL_W-1:0]     l_col;
  logic                 rec;
  logic [RES_CNT_W-1:0] res_cnt;

  entry_t               rdata;
  entry_t               wdata;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  entry_t               unit_ent;
  cmp_t                 cmp;

  logic [CW-1:0]        idx_p1;
  logic [CW-1:0]        nx_p1;
  logic [CW-1:0]        nx_p2;
  logic [CW-1:0]        ck_p1;
  logic [CW-1:0]        ck_m1;
  logic [CW-1:0]        ck_mg;
  logic [CW-1:0]        cnt_m1;
  logic                 has_next_scan;
  logic                 has_next_walk;
  logic                 full;
  logic                 capped;
  logic                 out_free;
  logic                 emit_room;
  logic                 emit_req;
  logic                 emit_fire;
  logic                 adv;
  logic                 e_valid;
  logic [COL_W-1:0]     e_first;
  logic [COL_W-1:0]     e_last;
  logic                 e_end;
  logic                 e_ovf;
  logic [VW_W-1:0]      vw_sel;

  ocsc_ram #(
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The head step looks at the latched entry; every other step at the read data.
  assign unit_ent = (state == ST_HEAD) ? ent : rdata;

  ocsc_unit u_unit (
    .ent   (unit_ent),
    .f_col (f_col),
    .l_col (l_col),
    .res   (cmp)
  );

  assign idx_p1        = idx + CW'(1);
  assign nx_p1         = nx + CW'(1);
  assign nx_p2         = nx + CW'(2);
  assign ck_p1         = ck + CW'(1);
  assign ck_m1         = ck - CW'(1);
  assign ck_mg         = ck - gone;
  assign cnt_m1        = cnt - CW'(1);
  assign has_next_scan = idx_p1 < cnt;
  assign has_next_walk = nx_p1 < cnt;
  assign full          = cnt == CW'(MAX_RANGES);
  assign capped        = res_cnt == RES_CNT_W'(MAX_RESULTS);
  assign out_free      = !result_valid || !result_stall;
  assign emit_room     = capped || out_free;
  assign adv           = !emit_req || emit_room;
  assign emit_fire     = emit_req && out_free && !capped;
  assign span_stall    = state != ST_IDLE;
  assign vw_sel        = init_pend ? VIEW_WIDTH_RESET : view_width_r;

  always_comb begin
    emit_req = 1'b0;
    e_valid  = 1'b1;
    e_first  = f_col;
    e_last   = l_col;
    e_end    = 1'b0;
    e_ovf    = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = ent;
    raddr    = '0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_CLR0: begin
        we    = 1'b1;
        wdata = '{first: SENT_LO, last: SENT_LEFT_LAST};
      end
      ST_CLR1: begin
        we    = 1'b1;
        waddr = AW'(1);
        wdata = '{first: ENT_W'(vw_sel), last: SENT_HI};
      end
      ST_SCAN: begin
        raddr = idx_p1[AW-1:0];
      end
      ST_HEAD: begin
        raddr = idx_p1[AW-1:0];
        if (cmp.f_lt_first) begin
          emit_req = 1'b1;
          if (cmp.l_lt_firstm1) begin
            e_end = 1'b1;
            e_ovf = rec && full;
            raddr = cnt_m1[AW-1:0];
          end else begin
            e_last = cmp.first_m1;
            e_end  = cmp.l_le_last;
          end
        end
      end
      ST_WALK: begin
        emit_req = 1'b1;
        e_first  = gap_first;
        // Hold the read address while stalled so the entry stays on the port.
        raddr    = emit_room ? nx_p2[AW-1:0] : nx_p1[AW-1:0];
        if (has_next_walk && !cmp.l_lt_firstm1) begin
          e_last = cmp.first_m1;
          e_end  = cmp.l_le_last;
        end else begin
          e_end = 1'b1;
        end
      end
      ST_SHIFT: begin
        we    = 1'b1;
        waddr = ck_p1[AW-1:0];
        wdata = rdata;
        raddr = ck_m1[AW-1:0];
      end
      ST_INS: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = '{first: ENT_W'(f_col), last: ENT_W'(l_col)};
      end
      ST_WB: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        raddr = nx_p1[AW-1:0];
      end
      ST_COMPACT: begin
        we    = ck < cnt;
        waddr = ck_mg[AW-1:0];
        wdata = rdata;
        raddr = ck_p1[AW-1:0];
      end
      ST_EMPTY: begin
        emit_req = 1'b1;
        e_valid  = 1'b0;
        e_first  = '0;
        e_last   = '0;
        e_end    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR0;
      init_pend    <= 1'b1;
      view_width_r <= VIEW_WIDTH_RESET;
      cnt          <= CW'(2);
      res_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        view_width_r <= cfg_wr_data;
      end

      if (emit_fire) begin
        result_valid <= 1'b1;
        frag_valid   <= e_valid;
        frag_first   <= e_first;
        frag_last    <= e_last;
        // Past the result limit the last kept item closes the run.
        run_end      <= e_end || (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));
        overflow     <= e_ovf;
        res_cnt      <= res_cnt + RES_CNT_W'(1);
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (span_valid) begin
            f_col   <= first_column;
            l_col   <= last_column;
            rec     <= action == ACT_SOLID;
            res_cnt <= '0;
            idx     <= '0;
            priority if (action == ACT_CLEAR) begin
              state <= ST_CLR0;
            end else if ((action == ACT_SOLID || action == ACT_PASS) &&
                         first_column <= last_column) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_EMPTY;
            end
          end
        end
        ST_CLR0: begin
          state <= ST_CLR1;
        end
        ST_CLR1: begin
          cnt       <= CW'(2);
          init_pend <= 1'b0;
          state     <= init_pend ? ST_IDLE : ST_EMPTY;
        end
        ST_SCAN: begin
          if (has_next_scan && cmp.last_lt_fm1) begin
            idx <= idx_p1;
          end else begin
            ent   <= rdata;
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (adv) begin
            if (cmp.f_lt_first && cmp.l_lt_firstm1) begin
              // The span sits wholly in the gap before entry s.
              if (rec && !full) begin
                ck    <= cnt_m1;
                state <= ST_SHIFT;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              if (cmp.f_lt_first && rec) begin
                ent.first <= ENT_W'(f_col);
              end
              nx        <= idx;
              gap_first <= cmp.last_p1;
              if (cmp.l_le_last) begin
                if (!cmp.f_lt_first) begin
                  state <= ST_EMPTY;
                end else begin
                  state <= rec ? ST_WB : ST_IDLE;
                end
              end else begin
                state <= ST_WALK;
              end
            end
          end
        end
        ST_WALK: begin
          if (adv) begin
            if (has_next_walk && !cmp.l_lt_firstm1) begin
              nx        <= nx_p1;
              gap_first <= cmp.last_p1;
              if (cmp.l_le_last) begin
                ent.last <= rdata.last;
                state    <= rec ? ST_WB : ST_IDLE;
              end
            end else begin
              ent.last <= ENT_W'(l_col);
              state    <= rec ? ST_WB : ST_IDLE;
            end
          end
        end
        ST_WB: begin
          if (nx == idx) begin
            state <= ST_IDLE;
          end else begin
            ck    <= nx_p1;
            gone  <= nx - idx;
            state <= ST_COMPACT;
          end
        end
        ST_COMPACT: begin
          if (ck < cnt) begin
            ck <= ck_p1;
          end else begin
            cnt   <= cnt - gone;
            state <= ST_IDLE;
          end
        end
        ST_SHIFT: begin
          if (ck == idx) begin
            state <= ST_INS;
          end else begin
            ck <= ck_m1;
          end
        end
        ST_INS: begin
          cnt   <= cnt + CW'(1);
          state <= ST_IDLE;
        end
        ST_EMPTY: begin
          if (adv) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
